// ===== rtl/cds_pkg.sv =====
// Shared types and constants for the coast-down identification sequencer.
// No dependencies; every rtl file imports this package.
package cds_pkg;

    localparam int AVG_WINDOW_LOG2 = 8;
    localparam int DATA_W          = 32;
    localparam int CNT_W           = 16;
    localparam int ACC_W           = 44;
    localparam int LIMIT_W         = 31;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CNT_W-1:0] AVG_WINDOW = CNT_W'(2 ** AVG_WINDOW_LOG2);

    // opcodes
    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPINUP_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOG_LENGTH   = 2'd3;

    // phase codes as reported on the result
    localparam logic [1:0] PHASE_CODE_SPIN  = 2'd0;
    localparam logic [1:0] PHASE_CODE_COAST = 2'd1;
    localparam logic [1:0] PHASE_CODE_FIN   = 2'd2;

    typedef enum logic [2:0] {
        PH_SPIN  = 3'b001,
        PH_COAST = 3'b010,
        PH_FIN   = 3'b100
    } t_phase;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_level;
        logic [LIMIT_W-1:0]       speed_limit;
        logic [CNT_W-1:0]         spinup_ticks;
        logic [CNT_W-1:0]         log_length;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] vq_drive;
        logic                     clear_control;
        logic                     stop_drive;
        logic [1:0]               phase_now;
        logic                     run_done;
        logic                     run_aborted;
        logic                     log_valid;
        logic [CNT_W-1:0]         log_index;
        logic signed [DATA_W-1:0] log_value;
        logic signed [DATA_W-1:0] steady_speed;
        logic signed [DATA_W-1:0] steady_current;
    } t_result;

endpackage

// ===== rtl/cds_cfg.sv =====
// Configuration register bank of the coast-down sequencer.
// Depends on cds_pkg for the register indexes and the t_cfg struct.
module cds_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cds_pkg::DATA_W-1:0]          i_cfg_data,
    output cds_pkg::t_cfg                       o_cfg
);
    import cds_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DRIVE_LEVEL:  n_cfg.drive_level  = $signed(i_cfg_data);
                REG_SPEED_LIMIT:  n_cfg.speed_limit  = i_cfg_data[LIMIT_W-1:0];
                REG_SPINUP_TICKS: n_cfg.spinup_ticks = i_cfg_data[CNT_W-1:0];
                REG_LOG_LENGTH:   n_cfg.log_length   = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_level  <= '0;
            r_cfg.speed_limit  <= '1;
            r_cfg.spinup_ticks <= CNT_W'(2000);
            r_cfg.log_length   <= CNT_W'(2000);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/cds_core.sv =====
// Run state and per-tick step logic: speed abort, spin-up averaging,
// coast-down sample logging. Depends on cds_pkg.
module cds_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_opcode,
    input  logic signed [cds_pkg::DATA_W-1:0] i_speed,
    input  logic signed [cds_pkg::DATA_W-1:0] i_current,
    input  cds_pkg::t_cfg                     i_cfg,
    output cds_pkg::t_result                  o_result
);
    import cds_pkg::*;

    t_phase                   r_phase,       n_phase;
    logic [CNT_W-1:0]         r_tick,        n_tick;
    logic [ACC_W-1:0]         r_speed_acc,   n_speed_acc;
    logic [ACC_W-1:0]         r_current_acc, n_current_acc;
    logic [CNT_W-1:0]         r_log_count,   n_log_count;
    logic signed [DATA_W-1:0] r_speed_avg,   n_speed_avg;
    logic signed [DATA_W-1:0] r_current_avg, n_current_avg;
    logic                     r_done,        n_done;
    logic                     r_abort,       n_abort;

    logic [DATA_W-1:0]        speed_mag;
    logic                     over_limit;
    logic [CNT_W-1:0]         eff_ticks;
    logic [CNT_W-1:0]         tick_inc;
    logic [CNT_W-1:0]         log_inc;
    logic signed [ACC_W-1:0]  speed_shift;
    logic signed [ACC_W-1:0]  current_shift;
    t_result                  res;

    // -0x80000000 wraps back to itself, which is the right magnitude
    assign speed_mag  = i_speed[DATA_W-1] ? (~i_speed + DATA_W'(1)) : i_speed;
    assign over_limit = speed_mag > {1'b0, i_cfg.speed_limit};
    assign eff_ticks  = (i_cfg.spinup_ticks < AVG_WINDOW) ? AVG_WINDOW : i_cfg.spinup_ticks;
    assign tick_inc   = r_tick + CNT_W'(1);
    assign log_inc    = r_log_count + CNT_W'(1);

    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_speed_acc   = r_speed_acc;
        n_current_acc = r_current_acc;
        n_log_count   = r_log_count;
        n_speed_avg   = r_speed_avg;
        n_current_avg = r_current_avg;
        n_done        = r_done;
        n_abort       = r_abort;
        speed_shift   = '0;
        current_shift = '0;
        res           = '0;

        if (i_opcode == OP_RESTART) begin
            n_phase       = PH_SPIN;
            n_tick        = '0;
            n_speed_acc   = '0;
            n_current_acc = '0;
            n_log_count   = '0;
            n_speed_avg   = '0;
            n_current_avg = '0;
            n_done        = 1'b0;
            n_abort       = 1'b0;
            res.clear_control = 1'b1;
        end else if (r_done || r_phase == PH_FIN) begin
            // finished run: hold terminal outputs
            n_done  = 1'b1;
            n_phase = PH_FIN;
            res.clear_control = 1'b1;
            res.stop_drive    = 1'b1;
        end else if (over_limit) begin
            n_done  = 1'b1;
            n_abort = 1'b1;
            n_phase = PH_FIN;
            res.clear_control = 1'b1;
            res.stop_drive    = 1'b1;
        end else begin
            case (r_phase)
                PH_SPIN: begin
                    res.vq_drive = i_cfg.drive_level;
                    n_tick = tick_inc;
                    // sum only over the last window of ticks
                    if (tick_inc > eff_ticks - AVG_WINDOW) begin
                        n_speed_acc   = r_speed_acc +
                                        {{(ACC_W-DATA_W){i_speed[DATA_W-1]}}, i_speed};
                        n_current_acc = r_current_acc +
                                        {{(ACC_W-DATA_W){i_current[DATA_W-1]}}, i_current};
                    end
                    if (tick_inc >= eff_ticks) begin
                        speed_shift   = $signed(n_speed_acc) >>> AVG_WINDOW_LOG2;
                        current_shift = $signed(n_current_acc) >>> AVG_WINDOW_LOG2;
                        n_speed_avg   = speed_shift[DATA_W-1:0];
                        n_current_avg = current_shift[DATA_W-1:0];
                        n_log_count   = '0;
                        n_phase       = PH_COAST;
                        res.vq_drive      = '0;
                        res.clear_control = 1'b1;
                    end
                end
                PH_COAST: begin
                    res.clear_control = 1'b1;
                    if (r_log_count < i_cfg.log_length) begin
                        res.log_valid = 1'b1;
                        res.log_index = r_log_count;
                        res.log_value = i_speed;
                        n_log_count   = log_inc;
                    end
                    if (n_log_count >= i_cfg.log_length) begin
                        n_done  = 1'b1;
                        n_phase = PH_FIN;
                        res.stop_drive = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        case (n_phase)
            PH_SPIN:  res.phase_now = PHASE_CODE_SPIN;
            PH_COAST: res.phase_now = PHASE_CODE_COAST;
            default:  res.phase_now = PHASE_CODE_FIN;
        endcase
        res.run_done       = n_done;
        res.run_aborted    = n_abort;
        res.steady_speed   = n_speed_avg;
        res.steady_current = n_current_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SPIN;
            r_tick        <= '0;
            r_speed_acc   <= '0;
            r_current_acc <= '0;
            r_log_count   <= '0;
            r_speed_avg   <= '0;
            r_current_avg <= '0;
            r_done        <= 1'b0;
            r_abort       <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_speed_acc   <= n_speed_acc;
            r_current_acc <= n_current_acc;
            r_log_count   <= n_log_count;
            r_speed_avg   <= n_speed_avg;
            r_current_avg <= n_current_avg;
            r_done        <= n_done;
            r_abort       <= n_abort;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/coastdown_ident_sequencer.sv =====
// Coast-down identification sequencer: one result beat for every input beat.
// A beat enters an input register; the step logic then updates the run state,
// fills the result register and raises o_valid. A new beat is taken every cycle
// while the output does not stall; the single step through the run state (two
// 44-bit accumulator adds per tick) sets that rate. Stall on the output holds the
// result register and, once the input register is also full, raises o_stall.
// Configuration writes take effect on the next beat processed.
// Uses cds_pkg, cds_cfg and cds_core.
module coastdown_ident_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic signed [cds_pkg::DATA_W-1:0]   i_speed_sample,
    input  logic signed [cds_pkg::DATA_W-1:0]   i_current_sample,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [cds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cds_pkg::DATA_W-1:0]          i_cfg_data,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cds_pkg::DATA_W-1:0]   o_vq_drive,
    output logic                                o_clear_control,
    output logic                                o_stop_drive,
    output logic [1:0]                          o_phase_now,
    output logic                                o_run_done,
    output logic                                o_run_aborted,
    output logic                                o_log_valid,
    output logic [cds_pkg::CNT_W-1:0]           o_log_index,
    output logic signed [cds_pkg::DATA_W-1:0]   o_log_value,
    output logic signed [cds_pkg::DATA_W-1:0]   o_steady_speed,
    output logic signed [cds_pkg::DATA_W-1:0]   o_steady_current
);
    import cds_pkg::*;

    t_cfg                     cfg;
    t_result                  step_res;

    logic                     r_in_valid;
    logic                     r_in_opcode;
    logic signed [DATA_W-1:0] r_in_speed;
    logic signed [DATA_W-1:0] r_in_current;
    logic                     r_out_valid;
    t_result                  r_out;

    logic                     out_free;
    logic                     advance;
    logic                     in_accept;

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    cds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cds_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_opcode  (r_in_opcode),
        .i_speed   (r_in_speed),
        .i_current (r_in_current),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    // input register: load on accept, drop once the beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_opcode  <= i_opcode;
            r_in_speed   <= i_speed_sample;
            r_in_current <= i_current_sample;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_vq_drive       = r_out.vq_drive;
    assign o_clear_control  = r_out.clear_control;
    assign o_stop_drive     = r_out.stop_drive;
    assign o_phase_now      = r_out.phase_now;
    assign o_run_done       = r_out.run_done;
    assign o_run_aborted    = r_out.run_aborted;
    assign o_log_valid      = r_out.log_valid;
    assign o_log_index      = r_out.log_index;
    assign o_log_value      = r_out.log_value;
    assign o_steady_speed   = r_out.steady_speed;
    assign o_steady_current = r_out.steady_current;

endmodule
